### hdl/skcb_pkg.sv
// ---------------------------------------------------------------------------
// skcb_pkg: shared types and constants of the scalar Kalman confidence band
// Holds the sequencer state type, the multiplier job codes and the
// configuration register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package skcb_pkg;

  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCORE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_THR    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DVI,
    ST_DIV,
    ST_MAG,
    ST_MUL,
    ST_SQRT,
    ST_OUT
  } state_t;

  // What the shared multiplier is currently working on.
  typedef enum logic [1:0] {
    MOP_STEP,
    MOP_VAR,
    MOP_HW,
    MOP_THR
  } mop_t;

endpackage

`default_nettype wire

### hdl/scalar_kalman_confidence_band_unit.sv
// ---------------------------------------------------------------------------
// scalar_kalman_confidence_band_unit: scalar Kalman filter with a band output
// Tracks a signed fixed-point observation stream and reports the estimate,
// a confidence band, the variance, counters and a band change flag.
// ---------------------------------------------------------------------------
// Each input word passes through one shift-add multiplier that handles a bit
// per cycle and serves four products, and through one compare-subtract stage
// shared by the gain divider (one quotient bit per cycle) and the square root
// (one root bit per cycle). A zero denominator skips the divider, and a
// stalled receiver holds the unit until the previous result has been taken.
// The default format is Q16.16. The input is stalled while a word is being
// worked on. The result sits in an output register until taken; the next
// word can be accepted in the cycle after the result has been written there.
// A write to any of the five configuration registers restarts the filter
// from the initial variance but keeps both counters.
`default_nettype none

module scalar_kalman_confidence_band_unit
  import skcb_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_wdata,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_bias,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic signed [DATA_WIDTH-1:0] out_band_center,
  output      logic signed [DATA_WIDTH-1:0] out_band_lower,
  output      logic signed [DATA_WIDTH-1:0] out_band_upper,
  output      logic [DATA_WIDTH-1:0]        out_band_radius,
  output      logic [DATA_WIDTH-1:0]        out_variance_out,
  output      logic [CNT_W-1:0]             out_observation_count,
  output      logic [CNT_W-1:0]             out_change_count,
  output      logic                         out_band_changed
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NP   = (W + F + 1) / 2;
  localparam int KW   = F + 1;
  localparam int QW   = (KW > NP) ? KW : NP;
  localparam int AW0  = (W > KW) ? W : KW;
  localparam int AW   = (AW0 > NP) ? AW0 : NP;
  localparam int PW   = 2 * AW;
  localparam int SW0  = W + 2;
  localparam int SW1  = NP + 3;
  localparam int SW   = ((SW0 > SW1) ? SW0 : SW1) + 1;
  localparam int CW   = $clog2(AW + 1);
  localparam int RDW  = 2 * NP;

  localparam logic [W-1:0]     UMAX  = {W{1'b1}};
  localparam logic [W-1:0]     SMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]     SMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [AW-1:0]    ONE_A = AW'(1) << F;
  localparam logic [CNT_W-1:0] CMAX  = {CNT_W{1'b1}};

  state_t state_r, state_nxt;
  mop_t   mop_r, mop_nxt;

  logic [W-1:0] init_var_r, proc_noise_r, meas_noise_r, z_score_r, chg_thr_r;
  logic [W-1:0] est_r, est_nxt, var_r, var_nxt, prev_r, prev_nxt;
  logic         seeded_r, seeded_nxt, pvalid_r, pvalid_nxt;
  logic [CNT_W-1:0] scount_r, scount_nxt, ccount_r, ccount_nxt;

  logic [W-1:0]  obs_r, obs_nxt, ppred_r, ppred_nxt, den_r, den_nxt;
  logic [W-1:0]  mag_r, mag_nxt, hw_r, hw_nxt, thr_r, thr_nxt;
  logic          neg_r, neg_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic [SW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  qr_r, qr_nxt;
  logic [RDW-1:0] rad_r, rad_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  acc_r, acc_nxt, ma_r, ma_nxt;
  logic [AW-1:0]  mb_r, mb_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [W-1:0]   o_center_r, o_lower_r, o_upper_r;
  logic [W-1:0]          o_hw_r, o_var_r;
  logic [CNT_W-1:0]      o_scount_r, o_ccount_r;
  logic                  o_changed_r;
  logic                  out_load;

  // Shared compare-subtract used by both the divider and the square root.
  logic [SW-1:0] cs_cand, cs_trial, cs_diff;
  logic          cs_ge;

  logic [W:0]    sum_pq, sum_pr;
  logic [PW-1:0] mul_shift;
  logic [W-1:0]  mul_res, step_w;
  logic [W+1:0]  up_sum, lo_dif;
  logic [W-1:0]  upper_w, lower_w, hw_diff;
  logic          changed_w;
  logic          in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  assign sum_pq = {1'b0, var_r} + {1'b0, proc_noise_r};
  assign sum_pr = {1'b0, ppred_r} + {1'b0, meas_noise_r};

  always_comb begin
    if (state_r == ST_SQRT) begin
      cs_cand  = {rem_r[SW-3:0], rad_r[RDW-1 -: 2]};
      cs_trial = SW'({qr_r, 2'b01});
    end else begin
      cs_cand  = {rem_r[SW-2:0], 1'b0};
      cs_trial = SW'(den_r);
    end
    cs_ge   = (cs_cand >= cs_trial);
    cs_diff = cs_cand - cs_trial;
  end

  // Truncate product to fixed-point grid, saturate to UMAX; cap step at mag_r.
  always_comb begin
    mul_shift = acc_r >> F;
    mul_res   = (|mul_shift[PW-1:W]) ? UMAX : mul_shift[W-1:0];
    step_w    = (mul_res > mag_r) ? mag_r : mul_res;
  end

  always_comb begin
    up_sum  = {{2{est_r[W-1]}}, est_r} + {2'b00, hw_r};
    lo_dif  = {{2{est_r[W-1]}}, est_r} - {2'b00, hw_r};
    upper_w = (!up_sum[W+1] && (up_sum[W:W-1] != 2'b00)) ? SMAX : up_sum[W-1:0];
    lower_w = (lo_dif[W+1] && (lo_dif[W:W-1] != 2'b11)) ? SMIN : lo_dif[W-1:0];
    hw_diff = (hw_r > prev_r) ? (hw_r - prev_r) : (prev_r - hw_r);
    changed_w = pvalid_r && (prev_r != '0) && (hw_diff > thr_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DVI;
      ST_DVI:  state_nxt = (den_r == '0) ? ST_MAG : ST_DIV;
      ST_DIV:  if (cnt_r == CW'(F)) state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == CW'(AW)) begin
          unique case (mop_r)
            MOP_STEP: state_nxt = ST_MUL;
            MOP_VAR:  state_nxt = ST_SQRT;
            MOP_HW:   state_nxt = ST_MUL;
            MOP_THR:  state_nxt = ST_OUT;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQRT: if (cnt_r == CW'(NP)) state_nxt = ST_MUL;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values.
  always_comb begin
    mop_nxt    = mop_r;
    est_nxt    = est_r;
    var_nxt    = var_r;
    prev_nxt   = prev_r;
    seeded_nxt = seeded_r;
    pvalid_nxt = pvalid_r;
    scount_nxt = scount_r;
    ccount_nxt = ccount_r;
    obs_nxt    = obs_r;
    ppred_nxt  = ppred_r;
    den_nxt    = den_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    hw_nxt     = hw_r;
    thr_nxt    = thr_r;
    k_nxt      = k_r;
    rem_nxt    = rem_r;
    qr_nxt     = qr_r;
    rad_nxt    = rad_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          obs_nxt    = in_bias;
          if (!seeded_r) est_nxt = in_bias;
          seeded_nxt = 1'b1;
          if (scount_r != CMAX) scount_nxt = scount_r + 1'b1;
        end
      end
      ST_PRED: ppred_nxt = sum_pq[W] ? UMAX : sum_pq[W-1:0];
      ST_DEN:  den_nxt = sum_pr[W] ? UMAX : sum_pr[W-1:0];
      ST_DVI: begin
        cnt_nxt = '0;
        k_nxt   = '0;
        if (ppred_r == den_r) begin
          qr_nxt  = QW'(1);
          rem_nxt = '0;
        end else begin
          qr_nxt  = '0;
          rem_nxt = SW'(ppred_r);
        end
      end
      ST_DIV: begin
        if (cnt_r == CW'(F)) begin
          k_nxt = qr_r[KW-1:0];
        end else begin
          rem_nxt = cs_ge ? cs_diff : cs_cand;
          qr_nxt  = {qr_r[QW-2:0], cs_ge};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MAG: begin
        neg_nxt = ($signed(obs_r) < $signed(est_r));
        mag_nxt = ($signed(obs_r) < $signed(est_r)) ? (est_r - obs_r) : (obs_r - est_r);
        mop_nxt = MOP_STEP;
        acc_nxt = '0;
        ma_nxt  = PW'(k_r);
        mb_nxt  = AW'(($signed(obs_r) < $signed(est_r)) ? (est_r - obs_r) : (obs_r - est_r));
        cnt_nxt = '0;
      end
      ST_MUL: begin
        if (cnt_r != CW'(AW)) begin
          if (mb_r[0]) acc_nxt = acc_r + ma_r;
          ma_nxt  = ma_r << 1;
          mb_nxt  = mb_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          unique case (mop_r)
            MOP_STEP: begin
              est_nxt = neg_r ? (est_r - step_w) : (est_r + step_w);
              mop_nxt = MOP_VAR;
              ma_nxt  = PW'(ONE_A - AW'(k_r));
              mb_nxt  = AW'(ppred_r);
            end
            MOP_VAR: begin
              var_nxt = mul_res;
              rem_nxt = '0;
              qr_nxt  = '0;
              rad_nxt = RDW'(mul_res) << F;
            end
            MOP_HW: begin
              hw_nxt  = mul_res;
              mop_nxt = MOP_THR;
              ma_nxt  = PW'(chg_thr_r);
              mb_nxt  = AW'(prev_r);
            end
            MOP_THR: thr_nxt = mul_res;
            default: ;
          endcase
        end
      end
      ST_SQRT: begin
        if (cnt_r == CW'(NP)) begin
          mop_nxt = MOP_HW;
          acc_nxt = '0;
          ma_nxt  = PW'(z_score_r);
          mb_nxt  = AW'(qr_r);
          cnt_nxt = '0;
        end else begin
          rem_nxt = cs_ge ? cs_diff : cs_cand;
          qr_nxt  = {qr_r[QW-2:0], cs_ge};
          rad_nxt = rad_r << 2;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          prev_nxt      = hw_r;
          pvalid_nxt    = 1'b1;
          if (changed_w && (ccount_r != CMAX)) ccount_nxt = ccount_r + 1'b1;
        end
      end
      default: ;
    endcase

    // Register writes restart filter; user writes only while idle, unchecked.
    if (cfg_we && (cfg_index <= REG_CHG_THR)) begin
      est_nxt    = '0;
      var_nxt    = (cfg_index == REG_INIT_VAR) ? cfg_wdata : init_var_r;
      seeded_nxt = 1'b0;
      prev_nxt   = '0;
      pvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mop_r        <= MOP_STEP;
      init_var_r   <= W'(65536);
      proc_noise_r <= W'(66);
      meas_noise_r <= W'(65536);
      z_score_r    <= W'(128452);
      chg_thr_r    <= W'(6554);
      est_r        <= '0;
      var_r        <= W'(65536);
      prev_r       <= '0;
      seeded_r     <= 1'b0;
      pvalid_r     <= 1'b0;
      scount_r     <= '0;
      ccount_r     <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mop_r       <= mop_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      prev_r      <= prev_nxt;
      seeded_r    <= seeded_nxt;
      pvalid_r    <= pvalid_nxt;
      scount_r    <= scount_nxt;
      ccount_r    <= ccount_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_VAR:   init_var_r   <= cfg_wdata;
          REG_PROC_NOISE: proc_noise_r <= cfg_wdata;
          REG_MEAS_NOISE: meas_noise_r <= cfg_wdata;
          REG_Z_SCORE:    z_score_r    <= cfg_wdata;
          REG_CHG_THR:    chg_thr_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    obs_r   <= obs_nxt;
    ppred_r <= ppred_nxt;
    den_r   <= den_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    hw_r    <= hw_nxt;
    thr_r   <= thr_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    qr_r    <= qr_nxt;
    rad_r   <= rad_nxt;
    acc_r   <= acc_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    if (out_load) begin
      o_center_r  <= est_r;
      o_lower_r   <= lower_w;
      o_upper_r   <= upper_w;
      o_hw_r      <= hw_r;
      o_var_r     <= var_r;
      o_scount_r  <= scount_r;
      o_ccount_r  <= (changed_w && (ccount_r != CMAX)) ? (ccount_r + 1'b1) : ccount_r;
      o_changed_r <= changed_w;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_band_center       = o_center_r;
  assign out_band_lower        = o_lower_r;
  assign out_band_upper        = o_upper_r;
  assign out_band_radius       = o_hw_r;
  assign out_variance_out      = o_var_r;
  assign out_observation_count = o_scount_r;
  assign out_change_count      = o_ccount_r;
  assign out_band_changed      = o_changed_r;

`ifndef SYNTHESIS
  // The gain never exceeds one.
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAG) |-> (AW'(k_r) <= ONE_A))
    else $error("gain above one");

  // The updated variance cannot exceed the predicted variance.
  a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SQRT) && ($past(state_r) == ST_MUL)) |-> (var_r <= ppred_r))
    else $error("updated variance above prediction");

  // The band always brackets its center.
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($signed(o_lower_r) <= $signed(o_center_r)) &&
                     ($signed(o_center_r) <= $signed(o_upper_r))))
    else $error("band does not bracket center");
`endif

endmodule

`default_nettype wire
